// ===== hdl/srs_pkg.sv =====
package srs_pkg;

  // Operation codes carried on the input channel.
  localparam logic [1:0] OP_SYN_WRITE = 2'd0;
  localparam logic [1:0] OP_INJECT    = 2'd1;
  localparam logic [1:0] OP_TICK      = 2'd2;

  // Configuration register indexes.
  localparam logic REG_LEAK_GAIN = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // Fixed field widths.
  localparam int unsigned POT_W   = 24;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned IDX8_W  = 8;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned GAIN_W  = 12;
  localparam int unsigned THR_W   = 23;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned RIDX_W  = 3;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned PROD_W  = POT_W + GAIN_W + 1;
  localparam int unsigned SYN_W   = IDX8_W + WGT_W;
  localparam longint unsigned HASH_MUL = 64'd2654435761;

  localparam logic signed [POT_W-1:0] POT_MAX = 24'sh7FFFFF;
  localparam logic signed [POT_W-1:0] POT_MIN = 24'sh800000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic syn_wr;
    logic hash_step;
    logic inj_rd;
    logic inj_wr;
    logic clr_step;
    logic tick_init;
    logic pot_rd;
    logic mul;
    logic eval;
    logic syn_rd;
    logic tgt_rd;
    logic tgt_wr;
    logic next_n;
    logic emit_next;
  } srs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic fire;
    logic last_slot;
    logic last_neuron;
    logic last_window;
  } srs_sts_t;

endpackage

// ===== hdl/spiking_reservoir_step_top.sv =====
// Leaky integrate-and-fire reservoir.
// Input requests arrive on the s_axis channel; tuser carries the operation:
// synapse write, input injection or one tick. Results leave on m_axis, one
// per readout window, in window order, with tlast on the final window.
// Registers leak_gain (address 0) and fire_threshold (address 4) are to be
// written over the APB port only while the block is idle; it does not enforce this.
// An injection passes the hash remainder unit (reciprocal multiply, then
// subtract). A tick walks every neuron, and the fanout of each neuron that
// fires, through the potential memory, then sends READOUT_DIMS results.
// One request is processed at a time; s_axis_tready is low until it is done.
// After reset the potential memory is cleared, and no request is accepted
// until that is done. Registers return to their defaults.
// When the receiver stalls, the current result holds on m_axis and the
// block waits; synapse contents are undefined until written.
module spiking_reservoir_step_top #(
  parameter int unsigned NEURONS      = 256,
  parameter int unsigned FANOUT       = 8,
  parameter int unsigned READOUT_DIMS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] source_neuron, [10:8] fanout_slot, [18:11] synapse_target,
  // [34:19] synapse_weight, [44:35] input_position, [60:45] input_value
  input  logic [63:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [8:0] window_spike_count, [17:9] total_spike_count
  output logic [23:0] m_axis_tdata,
  // [2:0] readout_index
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srs_pkg::*;

  logic [GAIN_W-1:0] leak_gain_q;
  logic [THR_W-1:0]  fire_threshold_q;
  srs_cmd_t          cmd;
  srs_sts_t          sts;
  logic [CNT_W-1:0]  win_cnt, tot_cnt;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_gain_q      <= GAIN_W'(3768);
      fire_threshold_q <= THR_W'(4096);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_LEAK_GAIN: leak_gain_q      <= pwdata[GAIN_W-1:0];
        REG_THRESHOLD: fire_threshold_q <= pwdata[THR_W-1:0];
        default:       leak_gain_q      <= leak_gain_q;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      REG_LEAK_GAIN: prdata = {{(32 - GAIN_W){1'b0}}, leak_gain_q};
      REG_THRESHOLD: prdata = {{(32 - THR_W){1'b0}}, fire_threshold_q};
      default:       prdata = '0;
    endcase
  end

  srs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srs_datapath #(
    .NEURONS      (NEURONS),
    .FANOUT       (FANOUT),
    .READOUT_DIMS (READOUT_DIMS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .leak_gain_i          (leak_gain_q),
    .fire_threshold_i     (fire_threshold_q),
    .source_neuron_i      (s_axis_tdata[7:0]),
    .fanout_slot_i        (s_axis_tdata[10:8]),
    .synapse_target_i     (s_axis_tdata[18:11]),
    .synapse_weight_i     (s_axis_tdata[34:19]),
    .input_position_i     (s_axis_tdata[44:35]),
    .input_value_i        (s_axis_tdata[60:45]),
    .readout_index_o      (m_axis_tuser),
    .window_spike_count_o (win_cnt),
    .total_spike_count_o  (tot_cnt)
  );

  assign m_axis_tdata = {6'b0, tot_cnt, win_cnt};
  assign m_axis_tlast = sts.last_window;

endmodule

// ===== hdl/srs_ram.sv =====
module srs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/srs_ctrl.sv =====
module srs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_op_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srs_pkg::srs_cmd_t cmd_o,
  input  srs_pkg::srs_sts_t sts_i
);
  import srs_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SYN, ST_HASH, ST_INJ_RD, ST_INJ_WR,
    ST_T_RD, ST_T_MUL, ST_T_EVAL, ST_S_RD, ST_S_TGT, ST_S_ADD,
    ST_T_NEXT, ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign accept      = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_SYN_WRITE: state_d = ST_SYN;
            OP_INJECT:    state_d = ST_HASH;
            OP_TICK:      state_d = ST_T_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_SYN:    state_d = ST_IDLE;
      ST_HASH:   if (sts_i.hash_done) state_d = ST_INJ_RD;
      ST_INJ_RD: state_d = ST_INJ_WR;
      ST_INJ_WR: state_d = ST_IDLE;
      ST_T_RD:   state_d = ST_T_MUL;
      ST_T_MUL:  state_d = ST_T_EVAL;
      ST_T_EVAL: state_d = sts_i.fire ? ST_S_RD : ST_T_NEXT;
      ST_S_RD:   state_d = ST_S_TGT;
      ST_S_TGT:  state_d = ST_S_ADD;
      ST_S_ADD:  state_d = sts_i.last_slot ? ST_T_NEXT : ST_S_RD;
      ST_T_NEXT: state_d = sts_i.last_neuron ? ST_EMIT : ST_T_RD;
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = sts_i.last_window ? ST_IDLE : ST_EMIT;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands decoded from the state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.clr_step  = (state_q == ST_CLEAR);
    cmd_o.load_in   = accept;
    cmd_o.tick_init = accept && (in_op_i == OP_TICK);
    cmd_o.syn_wr    = (state_q == ST_SYN);
    cmd_o.hash_step = (state_q == ST_HASH) && !sts_i.hash_done;
    cmd_o.inj_rd    = (state_q == ST_INJ_RD);
    cmd_o.inj_wr    = (state_q == ST_INJ_WR);
    cmd_o.pot_rd    = (state_q == ST_T_RD);
    cmd_o.mul       = (state_q == ST_T_MUL);
    cmd_o.eval      = (state_q == ST_T_EVAL);
    cmd_o.syn_rd    = (state_q == ST_S_RD);
    cmd_o.tgt_rd    = (state_q == ST_S_TGT);
    cmd_o.tgt_wr    = (state_q == ST_S_ADD);
    cmd_o.next_n    = (state_q == ST_T_NEXT);
    cmd_o.emit_next = (state_q == ST_EMIT) && out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/srs_datapath.sv =====
module srs_datapath #(
  parameter int unsigned NEURONS      = 256,
  parameter int unsigned FANOUT       = 8,
  parameter int unsigned READOUT_DIMS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srs_pkg::srs_cmd_t                   cmd_i,
  output srs_pkg::srs_sts_t                   sts_o,
  input  logic [srs_pkg::GAIN_W-1:0]          leak_gain_i,
  input  logic [srs_pkg::THR_W-1:0]           fire_threshold_i,
  input  logic [srs_pkg::IDX8_W-1:0]          source_neuron_i,
  input  logic [srs_pkg::SLOT_W-1:0]          fanout_slot_i,
  input  logic [srs_pkg::IDX8_W-1:0]          synapse_target_i,
  input  logic signed [srs_pkg::WGT_W-1:0]    synapse_weight_i,
  input  logic [srs_pkg::POS_W-1:0]           input_position_i,
  input  logic signed [srs_pkg::WGT_W-1:0]    input_value_i,
  output logic [srs_pkg::RIDX_W-1:0]          readout_index_o,
  output logic [srs_pkg::CNT_W-1:0]           window_spike_count_o,
  output logic [srs_pkg::CNT_W-1:0]           total_spike_count_o
);
  import srs_pkg::*;

  localparam int unsigned NW    = $clog2(NEURONS);
  localparam int unsigned SAW   = $clog2(NEURONS * FANOUT);
  localparam int unsigned FW    = (FANOUT > 1) ? $clog2(FANOUT) : 1;
  localparam int unsigned DW    = (READOUT_DIMS > 1) ? $clog2(READOUT_DIMS) : 1;
  localparam int unsigned WIN   = (NEURONS / READOUT_DIMS > 0) ? NEURONS / READOUT_DIMS : 1;
  localparam int unsigned CW    = $clog2(NEURONS + 1);
  localparam int unsigned HMOD  = 32'(HASH_MUL % 64'(NEURONS));
  localparam int unsigned HMW   = NW;
  localparam int unsigned HV_W  = POS_W + HMW;
  localparam int unsigned HSH   = HV_W + NW;
  localparam int unsigned HPW   = HSH + HV_W;
  localparam longint unsigned HRECIP =
    ((64'd1 << HSH) + 64'(NEURONS) - 64'd1) / 64'(NEURONS);

  // Captured request fields.
  logic [IDX8_W-1:0]       src_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [IDX8_W-1:0]       stgt_q;
  logic signed [WGT_W-1:0] sw_q;
  logic signed [WGT_W-1:0] val_q;

  // Hash remainder unit: reciprocal multiply, then subtract.
  logic [HV_W-1:0] hv_q;
  logic [1:0]      hcnt_q;
  logic [HV_W-1:0] hq_q;
  logic [NW-1:0]   rem_q;
  logic [HPW-1:0]  hprod;
  logic [HV_W-1:0] hrem;

  // Tick sequencing.
  logic [NW-1:0]   clr_q;
  logic [NW-1:0]   n_q;
  logic [SAW-1:0]  base_q;
  logic [FW-1:0]   f_q;
  logic [DW-1:0]   w_q;
  logic [CW-1:0]   c_q;
  logic [DW-1:0]   e_q;
  logic [CNT_W-1:0] cnt_q [READOUT_DIMS];
  logic [CNT_W-1:0] total_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [NW-1:0]   tgt_q;
  logic            tgt_ok_q;
  logic signed [WGT_W-1:0] wgt_q;

  // Memory ports.
  logic              pot_we;
  logic [NW-1:0]     pot_waddr, pot_raddr;
  logic [POT_W-1:0]  pot_wdata, pot_rdata;
  logic              syn_we;
  logic [SAW-1:0]    syn_waddr, syn_raddr;
  logic [SYN_W-1:0]  syn_rdata;

  logic [IDX8_W-1:0]       syn_t8;
  logic [NW+IDX8_W-1:0]    syn_text;
  logic signed [POT_W-1:0] leak_v;
  logic                    fire;
  logic signed [WGT_W-1:0] addend;
  logic signed [POT_W:0]   sum;
  logic signed [POT_W-1:0] sat;

  srs_ram #(.WIDTH(POT_W), .DEPTH(NEURONS)) u_pot_ram (
    .clk_i   (clk_i),
    .we_i    (pot_we),
    .waddr_i (pot_waddr),
    .wdata_i (pot_wdata),
    .raddr_i (pot_raddr),
    .rdata_o (pot_rdata)
  );

  srs_ram #(.WIDTH(SYN_W), .DEPTH(NEURONS * FANOUT)) u_syn_ram (
    .clk_i   (clk_i),
    .we_i    (syn_we),
    .waddr_i (syn_waddr),
    .wdata_i ({sw_q, stgt_q}),
    .raddr_i (syn_raddr),
    .rdata_o (syn_rdata)
  );

  // Hash reduction: quotient by reciprocal, remainder by subtraction.
  assign hprod = HPW'(hv_q) * HPW'(HRECIP);
  assign hrem  = hv_q - hq_q * HV_W'(NEURONS);

  // Synapse write address and range check.
  assign syn_we    = cmd_i.syn_wr && (int'(src_q) < NEURONS) && (int'(slot_q) < FANOUT);
  assign syn_waddr = SAW'(int'(src_q) * FANOUT + int'(slot_q));
  assign syn_raddr = base_q + SAW'(f_q);

  // Target from the synapse word.
  assign syn_t8   = syn_rdata[IDX8_W-1:0];
  assign syn_text = {{NW{1'b0}}, syn_t8};

  // Leak result and threshold compare.
  assign leak_v = prod_q[FRAC_W +: POT_W];
  assign fire   = $signed({leak_v[POT_W-1], leak_v}) >= $signed({2'b00, fire_threshold_i});

  // Saturating add for injections and synaptic weights.
  assign addend = cmd_i.tgt_wr ? wgt_q : val_q;
  assign sum    = $signed({pot_rdata[POT_W-1], pot_rdata}) +
                  $signed({{(POT_W + 1 - WGT_W){addend[WGT_W-1]}}, addend});
  always_comb begin
    if (sum[POT_W] != sum[POT_W-1]) begin
      sat = sum[POT_W] ? POT_MIN : POT_MAX;
    end else begin
      sat = sum[POT_W-1:0];
    end
  end

  // Potential memory port selection.
  always_comb begin
    if (cmd_i.pot_rd) begin
      pot_raddr = n_q;
    end else if (cmd_i.tgt_rd) begin
      pot_raddr = syn_text[NW-1:0];
    end else begin
      pot_raddr = rem_q;
    end
    pot_we    = cmd_i.clr_step || cmd_i.eval || cmd_i.inj_wr || (cmd_i.tgt_wr && tgt_ok_q);
    pot_waddr = rem_q;
    pot_wdata = sat;
    if (cmd_i.clr_step) begin
      pot_waddr = clr_q;
      pot_wdata = '0;
    end else if (cmd_i.eval) begin
      pot_waddr = n_q;
      pot_wdata = fire ? '0 : leak_v;
    end else if (cmd_i.tgt_wr) begin
      pot_waddr = tgt_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      src_q  <= source_neuron_i;
      slot_q <= fanout_slot_i;
      stgt_q <= synapse_target_i;
      sw_q   <= synapse_weight_i;
      val_q  <= input_value_i;
      hv_q   <= HV_W'(input_position_i) * HV_W'(HMOD);
    end
    if (cmd_i.hash_step && (hcnt_q == 2'd2)) begin
      hq_q <= hprod[HSH +: HV_W];
    end
    if (cmd_i.mul) begin
      prod_q <= $signed(pot_rdata) * $signed({1'b0, leak_gain_i});
    end
    if (cmd_i.tgt_rd) begin
      tgt_q    <= syn_text[NW-1:0];
      tgt_ok_q <= int'(syn_t8) < NEURONS;
      wgt_q    <= $signed(syn_rdata[SYN_W-1:IDX8_W]);
    end
  end

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      hcnt_q  <= '0;
      rem_q   <= '0;
      n_q     <= '0;
      base_q  <= '0;
      f_q     <= '0;
      w_q     <= '0;
      c_q     <= '0;
      e_q     <= '0;
      total_q <= '0;
      for (int i = 0; i < READOUT_DIMS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + NW'(1);
      end
      if (cmd_i.load_in) begin
        hcnt_q <= 2'd2;
        rem_q  <= '0;
      end else if (cmd_i.hash_step) begin
        hcnt_q <= hcnt_q - 2'd1;
        if (hcnt_q == 2'd1) begin
          rem_q <= hrem[NW-1:0];
        end
      end
      if (cmd_i.tick_init) begin
        n_q     <= '0;
        base_q  <= '0;
        w_q     <= '0;
        c_q     <= '0;
        e_q     <= '0;
        total_q <= '0;
        for (int i = 0; i < READOUT_DIMS; i++) begin
          cnt_q[i] <= '0;
        end
      end
      if (cmd_i.eval) begin
        f_q <= '0;
        if (fire) begin
          cnt_q[w_q] <= cnt_q[w_q] + CNT_W'(1);
          total_q    <= total_q + CNT_W'(1);
        end
      end
      if (cmd_i.tgt_wr) begin
        f_q <= f_q + FW'(1);
      end
      if (cmd_i.next_n) begin
        n_q    <= n_q + NW'(1);
        base_q <= base_q + SAW'(FANOUT);
        if (w_q != DW'(READOUT_DIMS - 1)) begin
          if (c_q == CW'(WIN - 1)) begin
            w_q <= w_q + DW'(1);
            c_q <= '0;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
      end
      if (cmd_i.emit_next) begin
        e_q <= e_q + DW'(1);
      end
    end
  end

  // Status.
  assign sts_o.clr_done    = (clr_q == NW'(NEURONS - 1));
  assign sts_o.hash_done   = (hcnt_q == '0);
  assign sts_o.fire        = fire;
  assign sts_o.last_slot   = (f_q == FW'(FANOUT - 1));
  assign sts_o.last_neuron = (n_q == NW'(NEURONS - 1));
  assign sts_o.last_window = (e_q == DW'(READOUT_DIMS - 1));

  // Readout.
  assign readout_index_o      = RIDX_W'(e_q);
  assign window_spike_count_o = cnt_q[e_q];
  assign total_spike_count_o  = total_q;

endmodule
